// ===== hdl/stgi_pkg.sv =====
// shared constants, widths, status codes and the exp2 root table
// no dependencies
package stgi_pkg;

	localparam int MAX_STOPS = 8;
	localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int CNT_W = $clog2(MAX_STOPS + 1);

	localparam int ZOOM_W = 13;
	localparam int VAL_W = 32;
	localparam int SIDX_W = 3;
	localparam int CFG_W = 4;
	localparam int STAT_W = 3;
	localparam int EXP_STEPS = 16;

	localparam logic [STAT_W-1:0] ST_WRITE = 3'd0;
	localparam logic [STAT_W-1:0] ST_INTERP = 3'd1;
	localparam logic [STAT_W-1:0] ST_EQUAL = 3'd2;
	localparam logic [STAT_W-1:0] ST_UPPER = 3'd3;
	localparam logic [STAT_W-1:0] ST_LOWER = 3'd4;
	localparam logic [STAT_W-1:0] ST_NONE = 3'd5;

	localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [VAL_W-1:0] SAT_VAL = 32'hFFFF_FFFF;
	localparam logic [31:0] ACC_ONE = 32'h4000_0000;

	// root of 2^(2^-k) in q2.30, chained integer square roots from 2.0
	function automatic logic [31:0] exp_root(input int k);
		logic [63:0] root;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		root = 64'h8000_0000;
		for (int j = 0; j < k; j++) begin
			v = root << 30;
			res = '0;
			b = 64'h1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			root = res;
		end
		return root[31:0];
	endfunction

	localparam logic [31:0] EXP_ROOTS [EXP_STEPS] = '{
		exp_root(1), exp_root(2), exp_root(3), exp_root(4),
		exp_root(5), exp_root(6), exp_root(7), exp_root(8),
		exp_root(9), exp_root(10), exp_root(11), exp_root(12),
		exp_root(13), exp_root(14), exp_root(15), exp_root(16)
	};

endpackage

// ===== hdl/stgi_if.sv =====
// input and result channel interfaces, valid/ready with payload
// depends on stgi_pkg
interface stgi_in_if;
	import stgi_pkg::*;
	logic valid;
	logic ready;
	logic action;
	logic [SIDX_W-1:0] stop_index;
	logic [ZOOM_W-1:0] stop_zoom;
	logic [VAL_W-1:0] stop_value;
	logic [ZOOM_W-1:0] zoom;
	modport source (output valid, action, stop_index, stop_zoom, stop_value, zoom,
		input ready);
	modport sink (input valid, action, stop_index, stop_zoom, stop_value, zoom,
		output ready);
endinterface

interface stgi_out_if;
	import stgi_pkg::*;
	logic valid;
	logic ready;
	logic [VAL_W-1:0] value;
	logic [STAT_W-1:0] status;
	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// ===== hdl/stgi_table.sv =====
// stop table storage, one write port and one registered read port
// depends on stgi_pkg
module stgi_table (
	input  logic                       clk,
	input  logic                       we,
	input  logic [stgi_pkg::IDX_W-1:0] waddr,
	input  logic [stgi_pkg::ZOOM_W-1:0] wzoom,
	input  logic [stgi_pkg::VAL_W-1:0] wvalue,
	input  logic [stgi_pkg::IDX_W-1:0] raddr,
	output logic [stgi_pkg::ZOOM_W-1:0] rzoom,
	output logic [stgi_pkg::VAL_W-1:0] rvalue
);
	import stgi_pkg::*;

	logic [ZOOM_W-1:0] zoom_mem [MAX_STOPS];
	logic [VAL_W-1:0] value_mem [MAX_STOPS];

	always_ff @(posedge clk) begin
		if (we) begin
			zoom_mem[waddr] <= wzoom;
			value_mem[waddr] <= wvalue;
		end
		rzoom <= zoom_mem[raddr];
		rvalue <= value_mem[raddr];
	end

endmodule

// ===== hdl/stgi_mul.sv =====
// shared 32 by 32 unsigned multiplier with registered product
// depends on nothing
module stgi_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

// ===== hdl/stop_table_geometric_interpolator.sv =====
// top level: sequencer, scan, divider, log2/exp2 steps and result register
// depends on stgi_pkg, stgi_if, stgi_table, stgi_mul
//
// Evaluates a geometric interpolation over a table of stops. A write beat goes
// straight to the finish state. An evaluate beat reads and compares each scanned
// stop, then finishes at once unless it interpolates. An interpolated beat runs
// the divider and, unless a stop value is zero, two log2 passes of normalize and
// square/normalize steps, then the exp2 steps and a final multiply and shift.
// Every multiply goes through the one shared registered multiplier; the block
// takes no new beat until the current one has finished.
// A finished result waits in the output register while the next beat is taken.
module stop_table_geometric_interpolator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [stgi_pkg::CFG_W-1:0]  cfg_wr_data,
	stgi_in_if.sink                     in_ch,
	stgi_out_if.source                  out_ch
);
	import stgi_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SCAN_RD = 5'd1;
	localparam logic [4:0] S_SCAN_CMP = 5'd2;
	localparam logic [4:0] S_DECIDE = 5'd3;
	localparam logic [4:0] S_DIV = 5'd4;
	localparam logic [4:0] S_POST = 5'd5;
	localparam logic [4:0] S_LZ = 5'd6;
	localparam logic [4:0] S_LZ_W = 5'd7;
	localparam logic [4:0] S_NORM = 5'd8;
	localparam logic [4:0] S_SQ_MUL = 5'd9;
	localparam logic [4:0] S_SQ_NRM = 5'd10;
	localparam logic [4:0] S_DIFF = 5'd11;
	localparam logic [4:0] S_PM_W = 5'd12;
	localparam logic [4:0] S_EXP = 5'd13;
	localparam logic [4:0] S_EXP_W = 5'd14;
	localparam logic [4:0] S_FMUL = 5'd15;
	localparam logic [4:0] S_FMUL_W = 5'd16;
	localparam logic [4:0] S_FIN = 5'd17;

	logic [4:0] state_q;
	logic [CFG_W-1:0] stop_count_q;

	logic [ZOOM_W-1:0] z_q, lo_z_q, hi_z_q;
	logic [VAL_W-1:0] lo_v_q, hi_v_q;
	logic has_lo_q, has_hi_q;
	logic [CNT_W-1:0] scan_i_q, cnt_q;

	logic [13:0] rem_q;
	logic [16:0] fac_q;
	logic [4:0] step_q;

	logic which_q;
	logic [31:0] m_q;
	logic [4:0] e_q;
	logic [15:0] frac_q;
	logic [20:0] lhi_q;

	logic neg_q;
	logic [6:0] n_q;
	logic [15:0] r_q;
	logic [31:0] acc_q;

	logic [VAL_W-1:0] res_q;
	logic [STAT_W-1:0] st_q;

	logic out_v_q;
	logic [VAL_W-1:0] out_val_q;
	logic [STAT_W-1:0] out_st_q;

	logic [ZOOM_W-1:0] rd_zoom;
	logic [VAL_W-1:0] rd_value;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	logic in_acc;
	logic tbl_we;
	logic [13:0] span;
	logic div_bit;
	logic [13:0] rem_sub;
	logic [32:0] sq;
	logic [15:0] frac_nx;
	logic [21:0] diff;
	logic [20:0] mag;
	logic [21:0] pmag;
	logic [21:0] pmag_up;
	logic [3:0] step4;
	logic r_bit;
	logic [6:0] shamt;
	logic [65:0] shifted;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign tbl_we = in_acc && !in_ch.action && (32'(in_ch.stop_index) < MAX_STOPS);

	assign out_ch.valid = out_v_q;
	assign out_ch.value = out_val_q;
	assign out_ch.status = out_st_q;

	assign span = {1'b0, hi_z_q} - {1'b0, lo_z_q};
	assign div_bit = (rem_q >= span);
	assign rem_sub = div_bit ? (rem_q - span) : rem_q;
	assign sq = mul_p[63:31];
	assign frac_nx = {frac_q[14:0], sq[32]};
	assign diff = {1'b0, lhi_q} - {1'b0, e_q, frac_q};
	assign mag = diff[21] ? 21'(-diff) : diff[20:0];
	assign pmag = mul_p[37:16];
	assign pmag_up = pmag + 22'h00FFFF;
	assign step4 = step_q[3:0];
	assign r_bit = r_q[4'd15 - step4];
	assign shamt = 7'd32 - n_q;
	assign shifted = {mul_p, 2'b00} >> shamt;

	stgi_table u_table (
		.clk    (clk),
		.we     (tbl_we),
		.waddr  (IDX_W'(in_ch.stop_index)),
		.wzoom  (in_ch.stop_zoom),
		.wvalue (in_ch.stop_value),
		.raddr  (scan_i_q[IDX_W-1:0]),
		.rzoom  (rd_zoom),
		.rvalue (rd_value)
	);

	stgi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LZ: begin
				mul_a = 32'(fac_q);
				mul_b = hi_v_q;
			end
			S_SQ_MUL: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			S_DIFF: begin
				mul_a = 32'(mag);
				mul_b = 32'(fac_q);
			end
			S_EXP: begin
				mul_a = acc_q;
				mul_b = EXP_ROOTS[step4];
			end
			S_FMUL: begin
				mul_a = lo_v_q;
				mul_b = acc_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= '0;
		end else if (cfg_wr_en) begin
			stop_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_v_q || out_ch.ready)) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= in_ch.action ? S_SCAN_RD : S_FIN;
					end
				end
				S_SCAN_RD: state_q <= (scan_i_q == cnt_q) ? S_DECIDE : S_SCAN_CMP;
				S_SCAN_CMP: state_q <= S_SCAN_RD;
				S_DECIDE: begin
					if (has_lo_q && has_hi_q && lo_z_q != hi_z_q && lo_v_q != hi_v_q) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DIV: if (step_q == 5'd16) state_q <= S_POST;
				S_POST: begin
					priority if (lo_v_q == '0) state_q <= S_LZ;
					else if (hi_v_q == '0) state_q <= S_FIN;
					else state_q <= S_NORM;
				end
				S_LZ: state_q <= S_LZ_W;
				S_LZ_W: state_q <= S_FIN;
				S_NORM: if (m_q[31]) state_q <= S_SQ_MUL;
				S_SQ_MUL: state_q <= S_SQ_NRM;
				S_SQ_NRM: begin
					priority if (step_q != 5'd15) state_q <= S_SQ_MUL;
					else if (!which_q) state_q <= S_NORM;
					else state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_PM_W;
				S_PM_W: state_q <= S_EXP;
				S_EXP: begin
					priority if (r_bit) state_q <= S_EXP_W;
					else if (step_q == 5'd15) state_q <= S_FMUL;
					else state_q <= S_EXP;
				end
				S_EXP_W: state_q <= (step_q == 5'd15) ? S_FMUL : S_EXP;
				S_FMUL: state_q <= S_FMUL_W;
				S_FMUL_W: state_q <= S_FIN;
				S_FIN: begin
					if (!out_v_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_v_q || out_ch.ready)) begin
			out_val_q <= res_q;
			out_st_q <= st_q;
		end
		unique case (state_q)
			S_IDLE: begin
				z_q <= in_ch.zoom;
				scan_i_q <= '0;
				has_lo_q <= 1'b0;
				has_hi_q <= 1'b0;
				res_q <= '0;
				st_q <= ST_WRITE;
				cnt_q <= (32'(stop_count_q) > MAX_STOPS) ? CNT_W'(MAX_STOPS)
					: CNT_W'(stop_count_q);
			end
			S_SCAN_CMP: begin
				if (rd_zoom <= z_q && (!has_lo_q || lo_z_q < rd_zoom)) begin
					has_lo_q <= 1'b1;
					lo_z_q <= rd_zoom;
					lo_v_q <= rd_value;
				end
				if (rd_zoom >= z_q && (!has_hi_q || hi_z_q > rd_zoom)) begin
					has_hi_q <= 1'b1;
					hi_z_q <= rd_zoom;
					hi_v_q <= rd_value;
				end
				scan_i_q <= scan_i_q + 1'b1;
			end
			S_DECIDE: begin
				rem_q <= {1'b0, z_q} - {1'b0, lo_z_q};
				fac_q <= '0;
				step_q <= '0;
				priority if (has_lo_q && has_hi_q) begin
					if (lo_z_q == hi_z_q || lo_v_q == hi_v_q) begin
						res_q <= lo_v_q;
						st_q <= ST_EQUAL;
					end else begin
						st_q <= ST_INTERP;
					end
				end else if (has_hi_q) begin
					res_q <= hi_v_q;
					st_q <= ST_UPPER;
				end else if (has_lo_q) begin
					res_q <= lo_v_q;
					st_q <= ST_LOWER;
				end else begin
					res_q <= ONE_Q16;
					st_q <= ST_NONE;
				end
			end
			S_DIV: begin
				rem_q <= {rem_sub[12:0], 1'b0};
				fac_q <= {fac_q[15:0], div_bit};
				step_q <= step_q + 1'b1;
			end
			S_POST: begin
				res_q <= (fac_q == '0) ? lo_v_q : '0;
				m_q <= hi_v_q;
				e_q <= 5'd31;
				which_q <= 1'b0;
			end
			S_LZ_W: res_q <= mul_p[47:16];
			S_NORM: begin
				step_q <= '0;
				frac_q <= '0;
				if (!m_q[31]) begin
					m_q <= {m_q[30:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			end
			S_SQ_NRM: begin
				frac_q <= frac_nx;
				step_q <= step_q + 1'b1;
				if (step_q == 5'd15 && !which_q) begin
					lhi_q <= {e_q, frac_nx};
					which_q <= 1'b1;
					m_q <= lo_v_q;
					e_q <= 5'd31;
				end else begin
					m_q <= sq[32] ? sq[32:1] : sq[31:0];
				end
			end
			S_DIFF: neg_q <= diff[21];
			S_PM_W: begin
				acc_q <= ACC_ONE;
				step_q <= '0;
				if (neg_q) begin
					n_q <= 7'(-{1'b0, pmag_up[21:16]});
					r_q <= 16'(-pmag);
				end else begin
					n_q <= {1'b0, pmag[21:16]};
					r_q <= pmag[15:0];
				end
			end
			S_EXP: if (!r_bit) step_q <= step_q + 1'b1;
			S_EXP_W: begin
				acc_q <= mul_p[61:30];
				step_q <= step_q + 1'b1;
			end
			S_FMUL_W: res_q <= (shifted[65:32] != '0) ? SAT_VAL : shifted[31:0];
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("input ready while a beat is in work");
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == ST_WRITE) |-> (out_ch.value == '0))
		else $error("write result with nonzero value");
	a_none_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == ST_NONE) |-> (out_ch.value == ONE_Q16))
		else $error("empty table result is not one");
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_v_q) |=> (out_v_q && state_q == S_IDLE))
		else $error("finished result not loaded");
`endif

endmodule
